// ===== design/pgt_pkg.sv =====
// Shared types and constants for the pointer gesture tracker.
package pgt_pkg;

    localparam int POS_W  = 12;
    localparam int TAG_W  = 2;
    localparam int RAD_W  = 25;
    localparam int TIME_W = 16;
    localparam int LEN_W  = 6;
    localparam int CFG_W  = 25;
    localparam int CIDX_W = 3;
    localparam int TALLY_W = 6;
    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;
    localparam logic [TIME_W-1:0]  DWELL_MAX = '1;

    // Register indexes of the configuration port.
    localparam logic [CIDX_W-1:0] REG_WINDOW_LEN     = 3'd0;
    localparam logic [CIDX_W-1:0] REG_HOLD_LEN       = 3'd1;
    localparam logic [CIDX_W-1:0] REG_TRACK_TIMEOUT  = 3'd2;
    localparam logic [CIDX_W-1:0] REG_STATIC_TIMEOUT = 3'd3;
    localparam logic [CIDX_W-1:0] REG_NEAR_RADIUS_SQ = 3'd4;

    // Detection tags.
    localparam logic [TAG_W-1:0] TAG_OTHER   = 2'd0;
    localparam logic [TAG_W-1:0] TAG_NO_SPOT = 2'd1;
    localparam logic [TAG_W-1:0] TAG_SPOT    = 2'd2;
    localparam logic [TAG_W-1:0] TAG_INVALID = 2'd3;

    // Event codes.
    localparam logic [3:0] EV_NOTHING      = 4'd0;
    localparam logic [3:0] EV_NONE_MOVE    = 4'd1;
    localparam logic [3:0] EV_MOVE_NONE    = 4'd2;
    localparam logic [3:0] EV_MOVE_STATIC  = 4'd3;
    localparam logic [3:0] EV_KEEP_MOVE    = 4'd4;
    localparam logic [3:0] EV_STATIC_NONE  = 4'd5;
    localparam logic [3:0] EV_TRACK_START  = 4'd6;
    localparam logic [3:0] EV_STATIC_MOVE  = 4'd7;
    localparam logic [3:0] EV_KEEP_STATIC  = 4'd8;
    localparam logic [3:0] EV_TRACK_FINISH = 4'd9;
    localparam logic [3:0] EV_TRACK_ABORT  = 4'd10;
    localparam logic [3:0] EV_KEEP_TRACK   = 4'd11;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_MOVING,
        MODE_STATIC,
        MODE_TRACKING
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } ctl_state_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [POS_W-1:0] y;
        logic [POS_W-1:0] x;
    } hist_entry_t;

    typedef struct packed {
        logic shift;
        logic rotate;
    } chain_ctrl_t;

endpackage

// ===== design/pgt_cell.sv =====
// One history cell: shifts in from the newer side, rotates in from the older side.
module pgt_cell (
    input  logic                clk,
    input  pgt_pkg::chain_ctrl_t ctrl,
    input  pgt_pkg::hist_entry_t newer,
    input  pgt_pkg::hist_entry_t older,
    output pgt_pkg::hist_entry_t q
);
    import pgt_pkg::*;

    hist_entry_t entry_reg;
    hist_entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.shift)
        begin
            entry_next = newer;
        end
        else if (ctrl.rotate)
        begin
            entry_next = older;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

// ===== design/pgt_dist.sv =====
// Squared distance between two points, registered.
module pgt_dist (
    input  logic                      clk,
    input  logic [pgt_pkg::POS_W-1:0] ax,
    input  logic [pgt_pkg::POS_W-1:0] ay,
    input  logic [pgt_pkg::POS_W-1:0] bx,
    input  logic [pgt_pkg::POS_W-1:0] by,
    output logic [pgt_pkg::RAD_W-1:0] dist_sq
);
    import pgt_pkg::*;

    logic [POS_W-1:0]   dx;
    logic [POS_W-1:0]   dy;
    logic [RAD_W-1:0]   d2_next;
    logic [RAD_W-1:0]   d2_reg;

    always_comb
    begin
        dx = (ax > bx) ? ax - bx : bx - ax;
        dy = (ay > by) ? ay - by : by - ay;
        d2_next = RAD_W'({12'd0, dx} * {12'd0, dx}) + RAD_W'({12'd0, dy} * {12'd0, dy});
    end

    always_ff @(posedge clk)
    begin
        d2_reg <= d2_next;
    end

    assign dist_sq = d2_reg;

endmodule

// ===== design/pointer_gesture_tracker.sv =====
// Top level of the pointer gesture tracker: history chain, scan control and mode machine.
//
//  channel | signals                          | direction | transaction when
//  --------+----------------------------------+-----------+------------------------
//  input   | in_valid/in_stall tag pos_x pos_y | in        | in_valid & !in_stall
//  result  | out_valid/out_stall event_res mode| out       | out_valid & !out_stall
//  config  | cfg_we cfg_index cfg_data         | in        | cfg_we
//
//  An item is first shifted into the cell chain, then the chain is rotated once
//  past the distance unit and its pipeline drained, and last the mode is
//  resolved. The single shared distance unit compares every cell in turn.
//  Reset clears control state and tallies; the history cells hold no reset.
//  A stalled result holds the machine in its finish step, and no new item is
//  taken until it leaves; a new item may be taken while a result still waits.
module pointer_gesture_tracker #(
    parameter int HISTORY_DEPTH = 40
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [pgt_pkg::TAG_W-1:0]  tag,
    input  logic [pgt_pkg::POS_W-1:0]  pos_x,
    input  logic [pgt_pkg::POS_W-1:0]  pos_y,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [3:0]                 event_res,
    output logic [1:0]                 mode,
    input  logic                       cfg_we,
    input  logic [pgt_pkg::CIDX_W-1:0] cfg_index,
    input  logic [pgt_pkg::CFG_W-1:0]  cfg_data
);
    import pgt_pkg::*;

    localparam int DEPTH = HISTORY_DEPTH;
    localparam int CB    = $clog2(DEPTH + 2);
    localparam int WW    = (CB > LEN_W) ? CB : LEN_W;
    localparam int MW    = WW + 3;
    localparam logic [WW-1:0] DEPTH_W = WW'(DEPTH);

    // Configuration registers
    logic [LEN_W-1:0]  window_len_reg;
    logic [LEN_W-1:0]  hold_len_reg;
    logic [TIME_W-1:0] track_timeout_reg;
    logic [TIME_W-1:0] static_timeout_reg;
    logic [RAD_W-1:0]  near_radius_sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg     <= LEN_W'(20);
            hold_len_reg       <= LEN_W'(10);
            track_timeout_reg  <= TIME_W'(100);
            static_timeout_reg <= TIME_W'(80);
            near_radius_sq_reg <= RAD_W'(400);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW_LEN:     window_len_reg     <= cfg_data[LEN_W-1:0];
                REG_HOLD_LEN:       hold_len_reg       <= cfg_data[LEN_W-1:0];
                REG_TRACK_TIMEOUT:  track_timeout_reg  <= cfg_data[TIME_W-1:0];
                REG_STATIC_TIMEOUT: static_timeout_reg <= cfg_data[TIME_W-1:0];
                REG_NEAR_RADIUS_SQ: near_radius_sq_reg <= cfg_data[RAD_W-1:0];
                default:            ;
            endcase
        end
    end

    // Effective window: window_len capped at the history depth
    logic [WW-1:0] win_ext;
    logic [WW-1:0] w_eff;
    logic [WW-1:0] hold_ext;
    assign win_ext  = WW'(window_len_reg);
    assign hold_ext = WW'(hold_len_reg);
    assign w_eff    = (win_ext < DEPTH_W) ? win_ext : DEPTH_W;

    // Control state
    ctl_state_t state_reg, state_next;
    logic [WW-1:0]      cnt_reg, cnt_next;
    mode_t              mode_reg, mode_next;
    logic [WW-1:0]      warm_reg, warm_next;
    logic [TIME_W-1:0]  dwell_reg, dwell_next;
    logic [2*POS_W-1:0] anchor_reg, anchor_next;
    logic [TALLY_W-1:0] tally_reg [3];
    logic [TALLY_W-1:0] tally_next [3];
    logic [TAG_W-1:0]   tag_reg;
    logic [POS_W-1:0]   px_reg;
    logic [POS_W-1:0]   py_reg;
    logic [TAG_W-1:0]   rm_tag_reg, rm_tag_next;
    logic               near_ok_reg, near_ok_next;
    logic               far_ok_reg, far_ok_next;
    logic               pv_reg;
    logic [WW-1:0]      pidx_reg;
    logic               out_valid_reg, out_valid_next;
    logic [3:0]         ev_reg, ev_next;
    logic [1:0]         mode_out_reg, mode_out_next;

    // FSM control outputs
    logic        accept;
    logic        finish_fire;
    logic        scan_step;
    chain_ctrl_t chain_ctrl;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == DEPTH_W)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall    = 1'b1;
        accept      = 1'b0;
        scan_step   = 1'b0;
        finish_fire = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                accept   = in_valid;
            end
            ST_SCAN:
            begin
                scan_step = (cnt_reg < DEPTH_W);
            end
            ST_FINISH:
            begin
                finish_fire = !(out_valid_reg && out_stall);
            end
            default: ;
        endcase
        chain_ctrl.shift  = accept;
        chain_ctrl.rotate = scan_step;
    end

    // History chain: cell k holds the entry k items back from the newest.
    // Rotation moves each cell toward the head so the head sees every entry once.
    hist_entry_t cells [DEPTH];
    hist_entry_t new_entry;
    logic [TAG_W-1:0] tag_m;

    assign tag_m = (tag == TAG_INVALID) ? TAG_OTHER : tag;
    assign new_entry = '{tag: tag_m, y: pos_y, x: pos_x};

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        pgt_cell u_cell (
            .clk   (clk),
            .ctrl  (chain_ctrl),
            .newer ((k == 0) ? new_entry : cells[(k == 0) ? 0 : k - 1]),
            .older (cells[(k == DEPTH - 1) ? 0 : k + 1]),
            .q     (cells[k])
        );
    end

    // Shared distance unit: compare the head cell against the current point
    // while moving, against the anchor otherwise.
    logic [POS_W-1:0] ref_x;
    logic [POS_W-1:0] ref_y;
    logic [RAD_W-1:0] dist_sq;

    assign ref_x = (mode_reg == MODE_MOVING) ? px_reg : anchor_reg[POS_W-1:0];
    assign ref_y = (mode_reg == MODE_MOVING) ? py_reg : anchor_reg[2*POS_W-1:POS_W];

    pgt_dist u_dist (
        .clk     (clk),
        .ax      (ref_x),
        .ay      (ref_y),
        .bx      (cells[0].x),
        .by      (cells[0].y),
        .dist_sq (dist_sq)
    );

    // Scan bookkeeping and nearness flags
    always_comb
    begin
        cnt_next     = cnt_reg;
        rm_tag_next  = rm_tag_reg;
        near_ok_next = near_ok_reg;
        far_ok_next  = far_ok_reg;
        if (accept)
        begin
            cnt_next     = '0;
            // the entry falling off the chain is the removal when the window spans it all
            rm_tag_next  = cells[DEPTH-1].tag;
            near_ok_next = 1'b1;
            far_ok_next  = 1'b1;
        end
        else if (state_reg == ST_SCAN)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (scan_step && (w_eff != '0) && (cnt_reg == w_eff))
            begin
                rm_tag_next = cells[0].tag;
            end
            if (pv_reg && (pidx_reg != '0) && (pidx_reg < hold_ext)
                && (dist_sq > near_radius_sq_reg))
            begin
                near_ok_next = 1'b0;
            end
            if (pv_reg && (pidx_reg < (w_eff >> 1)) && (dist_sq <= near_radius_sq_reg))
            begin
                far_ok_next = 1'b0;
            end
        end
    end

    // Tally update, majorities and mode machine
    logic              warm;
    logic [MW-1:0]     spot_lhs;
    logic [MW-1:0]     none_lhs;
    logic              spot_maj;
    logic              none_maj;
    logic [TIME_W-1:0] dwell_inc;
    logic [3:0]        ev;

    always_comb
    begin
        warm = (warm_reg == DEPTH_W);
        for (int k = 0; k < 3; k++)
        begin
            tally_next[k] = tally_reg[k];
            if (warm && (rm_tag_reg == TAG_W'(k)) && (tally_next[k] != '0))
            begin
                tally_next[k] = tally_next[k] - 1'b1;
            end
            if ((tag_reg == TAG_W'(k)) && (tally_next[k] != TALLY_MAX))
            begin
                tally_next[k] = tally_next[k] + 1'b1;
            end
        end
        spot_lhs  = MW'(tally_next[2]) * MW'(5);
        none_lhs  = MW'(tally_next[1]) * MW'(5);
        spot_maj  = spot_lhs >= (MW'(w_eff) << 2);
        none_maj  = none_lhs >= (MW'(w_eff) * MW'(3));
        dwell_inc = (dwell_reg == DWELL_MAX) ? dwell_reg : dwell_reg + 1'b1;

        mode_next   = mode_reg;
        dwell_next  = dwell_reg;
        anchor_next = anchor_reg;
        ev          = EV_NOTHING;
        if (warm)
        begin
            case (mode_reg)
                MODE_NONE:
                begin
                    if (tag_reg == TAG_SPOT && spot_maj)
                    begin
                        mode_next = MODE_MOVING;
                        ev        = EV_NONE_MOVE;
                    end
                end
                MODE_MOVING:
                begin
                    if (tag_reg == TAG_NO_SPOT && none_maj)
                    begin
                        mode_next = MODE_NONE;
                        ev        = EV_MOVE_NONE;
                    end
                    else if (tag_reg == TAG_SPOT && near_ok_reg)
                    begin
                        mode_next   = MODE_STATIC;
                        ev          = EV_MOVE_STATIC;
                        dwell_next  = TIME_W'(hold_len_reg);
                        anchor_next = {py_reg, px_reg};
                    end
                    else
                    begin
                        ev = EV_KEEP_MOVE;
                    end
                end
                MODE_STATIC:
                begin
                    dwell_next = dwell_inc;
                    if (tag_reg == TAG_NO_SPOT && none_maj)
                    begin
                        mode_next = MODE_NONE;
                        ev        = EV_STATIC_NONE;
                    end
                    else if (tag_reg == TAG_SPOT && spot_maj && far_ok_reg)
                    begin
                        mode_next  = MODE_TRACKING;
                        dwell_next = '0;
                        ev         = EV_TRACK_START;
                    end
                    else if (dwell_inc > static_timeout_reg)
                    begin
                        mode_next = MODE_MOVING;
                        ev        = EV_STATIC_MOVE;
                    end
                    else
                    begin
                        ev = EV_KEEP_STATIC;
                    end
                end
                default:
                begin
                    dwell_next = dwell_inc;
                    // abort wins over finish
                    if (dwell_inc > track_timeout_reg)
                    begin
                        mode_next = MODE_MOVING;
                        ev        = EV_TRACK_ABORT;
                    end
                    else if (tag_reg == TAG_NO_SPOT && none_maj)
                    begin
                        mode_next = MODE_NONE;
                        ev        = EV_TRACK_FINISH;
                    end
                    else
                    begin
                        ev = EV_KEEP_TRACK;
                    end
                end
            endcase
        end

        warm_next      = warm_reg;
        out_valid_next = out_valid_reg;
        ev_next        = ev_reg;
        mode_out_next  = mode_out_reg;
        if (accept && (warm_reg != DEPTH_W))
        begin
            warm_next = warm_reg + 1'b1;
        end
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (finish_fire)
        begin
            out_valid_next = 1'b1;
            ev_next        = ev;
            mode_out_next  = mode_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            mode_reg      <= MODE_NONE;
            warm_reg      <= '0;
            dwell_reg     <= '0;
            anchor_reg    <= '0;
            tally_reg[0]  <= '0;
            tally_reg[1]  <= '0;
            tally_reg[2]  <= '0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            warm_reg      <= warm_next;
            pv_reg        <= scan_step;
            out_valid_reg <= out_valid_next;
            if (finish_fire)
            begin
                mode_reg     <= mode_next;
                dwell_reg    <= dwell_next;
                anchor_reg   <= anchor_next;
                tally_reg[0] <= tally_next[0];
                tally_reg[1] <= tally_next[1];
                tally_reg[2] <= tally_next[2];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tag_reg <= tag_m;
            px_reg  <= pos_x;
            py_reg  <= pos_y;
        end
        rm_tag_reg   <= rm_tag_next;
        near_ok_reg  <= near_ok_next;
        far_ok_reg   <= far_ok_next;
        pidx_reg     <= cnt_reg;
        ev_reg       <= ev_next;
        mode_out_reg <= mode_out_next;
    end

    assign out_valid = out_valid_reg;
    assign event_res = ev_reg;
    assign mode      = mode_out_reg;

    // Checks
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_SCAN && cnt_reg == '0))
    else $error("accepted transaction did not start a scan");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cnt_reg <= DEPTH_W))
    else $error("scan counter ran past the chain length");

    assert property (@(posedge clk) disable iff (!rst_n)
        (finish_fire && !warm) |=> (out_valid && event_res == EV_NOTHING))
    else $error("event reported during warm-up");

endmodule
